>>> rtl/wvc_pkg.sv
package wvc_pkg;

    localparam int XW      = 24;          // position field width
    localparam int AW      = 18;          // internal angle width
    localparam int CW      = 36;          // CORDIC datapath width
    localparam int DVW     = 40;          // divider dividend / quotient width
    localparam int DSW     = 21;          // divider divisor width
    localparam int CORDIC_STEPS = 14;

    localparam logic signed [AW-1:0] ANG_PI     = 18'sd25736;
    localparam logic signed [AW:0]   ANG_TWO_PI = 19'sd51472;
    localparam logic [19:0]          US_PER_S   = 20'd1000000;
    localparam logic [19:0]          US_MIN     = 20'd1000;
    // floor(n / 1e6) = ((n >> 6) * US_RECIP) >> 44 for any n below 2^36
    localparam logic [30:0]          US_RECIP   = 31'd1125899907;

    // register indexes
    localparam logic [2:0] REG_MAX_LIN   = 3'd0;
    localparam logic [2:0] REG_MAX_TURN  = 3'd1;
    localparam logic [2:0] REG_TURN_THR  = 3'd2;
    localparam logic [2:0] REG_LIN_ACC   = 3'd3;
    localparam logic [2:0] REG_ANG_ACC   = 3'd4;
    localparam logic [2:0] REG_SPACING   = 3'd5;
    localparam logic [2:0] REG_POS_TOL   = 3'd6;
    localparam logic [2:0] REG_REV_EN    = 3'd7;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_CORD   = 12'b000000000010,
        S_BEAR   = 12'b000000000100,
        S_DIVC   = 12'b000000001000,
        S_TURN   = 12'b000000010000,
        S_DIVW   = 12'b000000100000,
        S_MULV   = 12'b000001000000,
        S_DIVV   = 12'b000010000000,
        S_LMUL1  = 12'b000100000000,
        S_LMUL2  = 12'b001000000000,
        S_LDIV   = 12'b010000000000,
        S_LAPPLY = 12'b100000000000
    } state_t;

    function automatic logic [12:0] atan_lut(input logic [3:0] i);
        case (i)
            4'd0:    atan_lut = 13'd6434;
            4'd1:    atan_lut = 13'd3798;
            4'd2:    atan_lut = 13'd2007;
            4'd3:    atan_lut = 13'd1019;
            4'd4:    atan_lut = 13'd511;
            4'd5:    atan_lut = 13'd256;
            4'd6:    atan_lut = 13'd128;
            4'd7:    atan_lut = 13'd64;
            4'd8:    atan_lut = 13'd32;
            4'd9:    atan_lut = 13'd16;
            4'd10:   atan_lut = 13'd8;
            4'd11:   atan_lut = 13'd4;
            4'd12:   atan_lut = 13'd2;
            4'd13:   atan_lut = 13'd1;
            default: atan_lut = 13'd0;
        endcase
    endfunction

endpackage

>>> rtl/wvc_cordic.sv
module wvc_cordic (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [wvc_pkg::XW-1:0] x_in,
    input  logic signed [wvc_pkg::XW-1:0] y_in,
    output logic                          done,
    output logic signed [wvc_pkg::AW-1:0] angle
);
    import wvc_pkg::*;

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [AW-1:0] z_reg, z_next;
    logic [3:0]           i_reg, i_next;
    logic                 run_reg, run_next, done_reg, done_next;
    logic signed [CW-1:0] xs, ys, x0, y0;
    logic signed [AW-1:0] at;

    always_comb
    begin
        x0 = {{(CW-XW-8){x_in[XW-1]}}, x_in, 8'd0};
        y0 = {{(CW-XW-8){y_in[XW-1]}}, y_in, 8'd0};
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        at = $signed({{(AW-13){1'b0}}, atan_lut(i_reg)});
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        run_next = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            // fold the left half-plane over by pi
            if (x0 < 0)
            begin
                x_next = -x0;
                y_next = -y0;
                z_next = (y0 >= 0) ? ANG_PI : -ANG_PI;
            end
            else
            begin
                x_next = x0;
                y_next = y0;
                z_next = '0;
            end
            i_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            else if (y_reg < 0)
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            i_next = i_reg + 4'd1;
            if (i_reg == 4'(CORDIC_STEPS - 1))
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            i_reg <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign angle = (z_reg > ANG_PI) ? ANG_PI : ((z_reg < -ANG_PI) ? -ANG_PI : z_reg);

endmodule

>>> rtl/wvc_div.sv
module wvc_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [wvc_pkg::DVW-1:0] dividend,
    input  logic [wvc_pkg::DSW-1:0] divisor,
    output logic                    done,
    output logic [wvc_pkg::DVW-1:0] quotient
);
    import wvc_pkg::*;

    logic [DVW-1:0] q_reg, q_next;
    logic [DSW-1:0] d_reg;
    logic [DSW:0]   r_reg, r_next, r_sh;
    logic [5:0]     n_reg, n_next;
    logic           run_reg, run_next, done_reg, done_next;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        r_sh = {r_reg[DSW-1:0], q_reg[DVW-1]};
        q_next = q_reg;
        r_next = r_reg;
        n_next = n_reg;
        run_next = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            n_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (r_sh >= {1'b0, d_reg})
            begin
                r_next = r_sh - {1'b0, d_reg};
                q_next = {q_reg[DVW-2:0], 1'b1};
            end
            else
            begin
                r_next = r_sh;
                q_next = {q_reg[DVW-2:0], 1'b0};
            end
            n_next = n_reg + 6'd1;
            if (n_reg == 6'(DVW - 1))
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            n_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            n_reg <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> rtl/waypoint_velocity_command.sv
// Channel  Direction  Handshake          Payload
// in       sink       in_valid/in_ready  target_x, target_y, target_heading, elapsed_us,
//                                        final_waypoint
// out      source     out_valid/out_ready linear_velocity, angular_velocity
// cfg      sink       APB write/read     8 registers at 4*i, pready tied high
//
// Each item passes through the CORDIC, then through the shared restoring divider (none,
// or up to three passes: speed cap on a final waypoint, turn rate and speed inside the
// proportional band), then the acceleration limit on each velocity in turn. The one
// multiplier serves every product in the steps after the CORDIC.
// Reset is asynchronous; registers come up at their defaults, last velocities zero.
// in_ready is high only when idle; a result waiting on out_ready holds the next one back.
module waypoint_velocity_command (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] target_x,
    input  logic [23:0] target_y,
    input  logic [15:0] target_heading,
    input  logic [19:0] elapsed_us,
    input  logic        final_waypoint,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [14:0] linear_velocity,
    output logic [15:0] angular_velocity,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wvc_pkg::*;

    logic [13:0] mls_reg;
    logic [14:0] mtr_reg, thr_reg;
    logic [15:0] lacc_reg, aacc_reg;
    logic [20:0] sp_reg, tol_reg;
    logic        rev_en_reg;

    state_t state_reg, state_next;

    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [15:0]   head_reg;
    logic [19:0]          us_reg;
    logic                 fin_reg, rev_reg, lane_reg, div_run_reg;
    logic signed [AW-1:0] eth_reg;
    logic [13:0]          cap_reg;
    logic signed [16:0]   vx_reg, wz_reg;
    logic signed [14:0]   last_v_reg, res_v_reg;
    logic signed [15:0]   last_w_reg, res_w_reg;
    logic [63:0]          prod_reg, lu_reg;
    logic [16:0]          step_reg;
    logic                 out_valid_reg;
    logic [14:0]          out_v_reg;
    logic [15:0]          out_w_reg;

    logic                 cord_start, cord_done, div_start, div_done, in_acc, wr;
    logic signed [AW-1:0] cord_angle, eth_rev, eth_bear, ae, th_s;
    logic signed [AW:0]   e1, e2;
    logic [DVW-1:0]       quot;
    logic [DSW-1:0]       div_divisor;
    logic [DVW-1:0]       div_dividend;
    logic [31:0]          mul_a, mul_b;
    logic [23:0]          abs_x, abs_d;
    logic signed [16:0]   tgt, last_s;
    logic signed [17:0]   d;
    logic [15:0]          lim;
    logic [17:0]          step;
    logic signed [19:0]   lim_res, lim_max;
    logic                 up, dn, tail_done;

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign pready   = 1'b1;
    assign wr       = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mls_reg <= 14'd1229;
            mtr_reg <= 15'd3215;
            thr_reg <= 15'd6434;
            lacc_reg <= 16'd1024;
            aacc_reg <= 16'd6431;
            sp_reg <= 21'd6554;
            tol_reg <= 21'd19661;
            rev_en_reg <= 1'b0;
        end
        else if (wr)
        begin
            case (paddr[4:2])
                REG_MAX_LIN:  mls_reg <= pwdata[13:0];
                REG_MAX_TURN: mtr_reg <= pwdata[14:0];
                REG_TURN_THR: thr_reg <= pwdata[14:0];
                REG_LIN_ACC:  lacc_reg <= pwdata[15:0];
                REG_ANG_ACC:  aacc_reg <= pwdata[15:0];
                REG_SPACING:  sp_reg <= pwdata[20:0];
                REG_POS_TOL:  tol_reg <= pwdata[20:0];
                REG_REV_EN:   rev_en_reg <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_MAX_LIN:  prdata = {18'd0, mls_reg};
            REG_MAX_TURN: prdata = {17'd0, mtr_reg};
            REG_TURN_THR: prdata = {17'd0, thr_reg};
            REG_LIN_ACC:  prdata = {16'd0, lacc_reg};
            REG_ANG_ACC:  prdata = {16'd0, aacc_reg};
            REG_SPACING:  prdata = {11'd0, sp_reg};
            REG_POS_TOL:  prdata = {11'd0, tol_reg};
            REG_REV_EN:   prdata = {31'd0, rev_en_reg};
            default:      prdata = '0;
        endcase
    end

    assign cord_start = in_acc;

    wvc_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .x_in  ($signed(target_x)),
        .y_in  ($signed(target_y)),
        .done  (cord_done),
        .angle (cord_angle)
    );

    assign div_start = (state_reg == S_DIVC || state_reg == S_DIVW || state_reg == S_DIVV)
                       && !div_run_reg;

    always_comb
    begin
        case (state_reg)
            S_DIVC:  div_divisor = (sp_reg == '0) ? DSW'(1) : sp_reg;
            default: div_divisor = {6'd0, thr_reg};
        endcase
        div_dividend = prod_reg[DVW-1:0];
    end

    wvc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quot)
    );

    // bearing adjust: reverse flip, then final-waypoint heading
    always_comb
    begin
        e1 = {cord_angle[AW-1], cord_angle} + {1'b0, ANG_PI};
        if (e1 >= ANG_TWO_PI)
        begin
            e1 = e1 - ANG_TWO_PI;
        end
        e2 = (e1 > {1'b0, ANG_PI}) ? e1 - ANG_TWO_PI : e1;
        eth_rev = rev_reg ? e2[AW-1:0] : cord_angle;
        if (fin_reg && ($signed({x_reg, 2'b00}) < $signed({5'd0, tol_reg})))
        begin
            eth_bear = {{(AW-16){head_reg[15]}}, head_reg};
        end
        else
        begin
            eth_bear = eth_rev;
        end
        abs_x = x_reg[XW-1] ? 24'(-x_reg) : 24'(x_reg);
        th_s  = $signed({3'd0, thr_reg});
        ae    = eth_reg[AW-1] ? -eth_reg : eth_reg;
    end

    // acceleration limit lane
    always_comb
    begin
        tgt    = lane_reg ? wz_reg : vx_reg;
        last_s = lane_reg ? 17'(last_w_reg) : 17'(last_v_reg);
        lim    = lane_reg ? aacc_reg : lacc_reg;
        d      = 18'(tgt) - 18'(last_s);
        abs_d  = d[17] ? 24'(-d) : 24'(d);
        step   = {1'b0, step_reg};
        up     = ((us_reg < US_MIN) && (d > 0)) || ((d > 0) && (prod_reg > lu_reg));
        dn     = (d < 0) && (prod_reg > lu_reg);
        if (up)
        begin
            lim_res = 20'(last_s) + $signed({2'b00, step});
        end
        else if (dn)
        begin
            lim_res = 20'(last_s) - $signed({2'b00, step});
        end
        else
        begin
            lim_res = 20'(tgt);
        end
        lim_max = lane_reg ? 20'sd32767 : 20'sd16383;
        if (lim_res > lim_max)
        begin
            lim_res = lim_max;
        end
        else if (lim_res < -lim_max)
        begin
            lim_res = -lim_max;
        end
    end

    always_comb
    begin
        case (state_reg)
            S_BEAR:  begin mul_a = {18'd0, mls_reg}; mul_b = {8'd0, abs_x}; end
            S_TURN:  begin mul_a = 32'(ae); mul_b = {17'd0, mtr_reg}; end
            S_MULV:  begin mul_a = {18'd0, cap_reg}; mul_b = 32'(th_s - ae); end
            S_LMUL1: begin mul_a = {16'd0, lim}; mul_b = {12'd0, us_reg}; end
            // step = floor(limit * us / 1e6) by reciprocal
            S_LMUL2: begin mul_a = {2'd0, prod_reg[35:6]}; mul_b = {1'b0, US_RECIP}; end
            S_LDIV:  begin mul_a = {8'd0, abs_d}; mul_b = {12'd0, US_PER_S}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign tail_done = (state_reg == S_LAPPLY) && lane_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_acc) state_next = S_CORD;
            S_CORD:   if (cord_done) state_next = S_BEAR;
            S_BEAR:   state_next = fin_reg ? S_DIVC : S_TURN;
            S_DIVC:   if (div_done) state_next = S_TURN;
            S_TURN:
            begin
                if (eth_reg > th_s || eth_reg < -th_s || thr_reg == '0)
                begin
                    state_next = S_LMUL1;
                end
                else
                begin
                    state_next = S_DIVW;
                end
            end
            S_DIVW:   if (div_done) state_next = S_MULV;
            S_MULV:   state_next = S_DIVV;
            S_DIVV:   if (div_done) state_next = S_LMUL1;
            S_LMUL1:  state_next = S_LMUL2;
            S_LMUL2:  state_next = S_LDIV;
            S_LDIV:   state_next = S_LAPPLY;
            S_LAPPLY:
            begin
                if (!lane_reg)
                begin
                    state_next = S_LMUL1;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            div_run_reg <= 1'b0;
            lane_reg <= 1'b0;
            last_v_reg <= '0;
            last_w_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_start)
            begin
                div_run_reg <= 1'b1;
            end
            else if (div_done)
            begin
                div_run_reg <= 1'b0;
            end
            if (in_acc)
            begin
                lane_reg <= 1'b0;
            end
            else if (state_reg == S_LAPPLY && !lane_reg)
            begin
                lane_reg <= 1'b1;
            end
            if (tail_done && (!out_valid_reg || out_ready))
            begin
                last_v_reg <= res_v_reg;
                last_w_reg <= lim_res[15:0];
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg <= $signed(target_x);
            y_reg <= $signed(target_y);
            head_reg <= $signed(target_heading);
            us_reg <= elapsed_us;
            fin_reg <= final_waypoint;
            rev_reg <= target_x[23] && rev_en_reg;
        end
        // |dv| * 1e6 stays put through the apply step
        if (state_reg != S_LAPPLY)
        begin
            prod_reg <= 64'(mul_a) * 64'(mul_b);
        end
        case (state_reg)
            S_BEAR:
            begin
                eth_reg <= eth_bear;
                cap_reg <= mls_reg;
            end
            S_DIVC:
            begin
                if (div_done && (quot < DVW'(mls_reg)))
                begin
                    cap_reg <= quot[13:0];
                end
            end
            S_TURN:
            begin
                if (eth_reg > th_s)
                begin
                    wz_reg <= $signed({2'b00, mtr_reg});
                    vx_reg <= '0;
                end
                else if (eth_reg < -th_s)
                begin
                    wz_reg <= -$signed({2'b00, mtr_reg});
                    vx_reg <= '0;
                end
                else
                begin
                    wz_reg <= '0;
                    vx_reg <= rev_reg ? -$signed({3'b000, cap_reg})
                                      : $signed({3'b000, cap_reg});
                end
            end
            S_DIVW:   wz_reg <= eth_reg[AW-1] ? -$signed(quot[16:0]) : $signed(quot[16:0]);
            S_DIVV:   vx_reg <= rev_reg ? -$signed(quot[16:0]) : $signed(quot[16:0]);
            S_LMUL2:  lu_reg <= prod_reg;
            S_LDIV:   step_reg <= prod_reg[60:44];
            S_LAPPLY: if (!lane_reg) res_v_reg <= lim_res[14:0];
            default:  ;
        endcase
        if (tail_done && (!out_valid_reg || out_ready))
        begin
            out_v_reg <= res_v_reg;
            out_w_reg <= lim_res[15:0];
        end
    end

    assign out_valid        = out_valid_reg;
    assign linear_velocity  = out_v_reg;
    assign angular_velocity = out_w_reg;

endmodule

>>> rtl/wvc_checker.sv
module wvc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [14:0] linear_velocity,
    input logic [15:0] angular_velocity,
    input logic        pready
);
    import wvc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(linear_velocity)
        && $stable(angular_velocity))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready straight after accepting an item");

    a_lin_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> linear_velocity != 15'h4000)
        else $error("linear velocity outside saturated range");

    a_ang_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> angular_velocity != 16'h8000)
        else $error("angular velocity outside saturated range");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind waypoint_velocity_command wvc_checker u_wvc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .linear_velocity  (linear_velocity),
    .angular_velocity (angular_velocity),
    .pready           (pready)
);
